// ----- sv/mclk_pkg.sv -----
// Package for the majority-clocked LFSR keystream block.
// Holds the payload and configuration types, the controller command and state types,
// and the shared constants. It depends on nothing else.
`timescale 1ns / 1ps

package mclk_pkg;

	// Register widths and top bits
	localparam int WIDTH_A = 19;
	localparam int WIDTH_B = 22;
	localparam int WIDTH_C = 23;
	localparam logic [WIDTH_A-1:0] TOP_A = 19'h40000;
	localparam logic [WIDTH_B-1:0] TOP_B = 22'h200000;
	localparam logic [WIDTH_C-1:0] TOP_C = 23'h400000;

	// Step counts
	localparam int KEY_BITS   = 64;
	localparam int FRAME_BITS = 22;
	localparam int MIX_STEPS  = 100;
	localparam int BYTE_STEPS = 8;
	localparam int WORD_STEPS = 32;
	localparam int INJ_W      = KEY_BITS + FRAME_BITS;
	localparam int CNT_W      = 7;

	localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(INJ_W - 1);
	localparam logic [CNT_W-1:0] MIX_LAST  = CNT_W'(MIX_STEPS - 1);
	localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(BYTE_STEPS - 1);
	localparam logic [CNT_W-1:0] WORD_LAST = CNT_W'(WORD_STEPS - 1);

	// Operation codes
	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_WORD = 2'd2;

	// Register indexes
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_TAP_A = 3'd0;
	localparam logic [2:0] REG_TAP_B = 3'd1;
	localparam logic [2:0] REG_TAP_C = 3'd2;
	localparam logic [2:0] REG_POS_A = 3'd3;
	localparam logic [2:0] REG_POS_B = 3'd4;
	localparam logic [2:0] REG_POS_C = 3'd5;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] session_key;
		logic [21:0] frame_number;
		logic [31:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic [31:0] keystream;
	} out_item_t;

	typedef struct packed {
		logic [WIDTH_A-1:0] tap_mask_a;
		logic [WIDTH_B-1:0] tap_mask_b;
		logic [WIDTH_C-1:0] tap_mask_c;
		logic [4:0]         clock_pos_a;
		logic [4:0]         clock_pos_b;
		logic [4:0]         clock_pos_c;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // take the request payload
		logic clear;     // zero the shift registers
		logic load_step; // plain step with key or frame bit at the top
		logic mix_step;  // majority step, no keystream
		logic gen_step;  // majority step, keystream bit shifted in
		logic word;      // word request: feedback keystream, full data
		logic emit;      // load the result register
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MIX,
		ST_GEN,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/majority_clocked_lfsr_keystream.sv -----
// Majority-clocked LFSR keystream generator, top level.
// Init: clears the shift registers, then runs the key/frame load steps and mix steps.
// Byte/word requests run keystream steps, then load the result register; in_ready
// stays low until idle. Registers step once per cycle via shared logic, not in emit.
// A result waiting in the output register does not block the next request.
// Reset (arst_n low, asynchronous) zeroes the shift registers and loads config defaults.
`timescale 1ns / 1ps

module majority_clocked_lfsr_keystream import mclk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;
	cmd_t cmd;

	// Configuration registers
	mclk_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	mclk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.operation),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Registers and keystream logic
	mclk_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ----- sv/mclk_cfg_regs.sv -----
// APB-style configuration registers for the keystream block.
// Depends on mclk_pkg for the register map and the cfg_t type.
`timescale 1ns / 1ps

module mclk_cfg_regs import mclk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes; unmapped indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_mask_a  <= '0;
			cfg_q.tap_mask_b  <= '0;
			cfg_q.tap_mask_c  <= '0;
			cfg_q.clock_pos_a <= 5'd8;
			cfg_q.clock_pos_b <= 5'd10;
			cfg_q.clock_pos_c <= 5'd10;
		end else if (wr_en) begin
			unique case (idx)
				REG_TAP_A: cfg_q.tap_mask_a  <= pwdata[WIDTH_A-1:0];
				REG_TAP_B: cfg_q.tap_mask_b  <= pwdata[WIDTH_B-1:0];
				REG_TAP_C: cfg_q.tap_mask_c  <= pwdata[WIDTH_C-1:0];
				REG_POS_A: cfg_q.clock_pos_a <= pwdata[4:0];
				REG_POS_B: cfg_q.clock_pos_b <= pwdata[4:0];
				REG_POS_C: cfg_q.clock_pos_c <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_TAP_A: prdata = {{(32-WIDTH_A){1'b0}}, cfg_q.tap_mask_a};
			REG_TAP_B: prdata = {{(32-WIDTH_B){1'b0}}, cfg_q.tap_mask_b};
			REG_TAP_C: prdata = {{(32-WIDTH_C){1'b0}}, cfg_q.tap_mask_c};
			REG_POS_A: prdata = {27'b0, cfg_q.clock_pos_a};
			REG_POS_B: prdata = {27'b0, cfg_q.clock_pos_b};
			REG_POS_C: prdata = {27'b0, cfg_q.clock_pos_c};
			default:   prdata = '0;
		endcase
	end

endmodule

// ----- sv/mclk_datapath.sv -----
// Datapath: the three Galois shift registers, key/frame injection shifter,
// keystream accumulator and result register. Depends on mclk_pkg.
`timescale 1ns / 1ps

module mclk_datapath import mclk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	input  in_item_t  in_data,
	output out_item_t out_data
);

	logic [WIDTH_A-1:0] sr_a_q, step_a, nxt_a;
	logic [WIDTH_B-1:0] sr_b_q, step_b, nxt_b;
	logic [WIDTH_C-1:0] sr_c_q, step_c, nxt_c;
	logic [31:0]        ext_a, ext_b, ext_c;
	logic [INJ_W-1:0]   inj_q;
	logic [31:0]        data_q;
	logic [31:0]        ks_q;
	out_item_t          res_q;
	logic               ca, cb, cc, maj;
	logic               mv_a, mv_b, mv_c;
	logic               ks_bit;

	// Galois step over the widest register; narrower ones are zero-extended
	function automatic logic [WIDTH_C-1:0] galois(
		input logic [WIDTH_C-1:0] r,
		input logic [WIDTH_C-1:0] m,
		input logic [WIDTH_C-1:0] t
	);
		if (r[0]) begin
			galois = ((r ^ m) >> 1) | t;
		end else begin
			galois = r >> 1;
		end
	endfunction

	assign step_a = WIDTH_A'(galois(WIDTH_C'(sr_a_q), WIDTH_C'(cfg.tap_mask_a), WIDTH_C'(TOP_A)));
	assign step_b = WIDTH_B'(galois(WIDTH_C'(sr_b_q), WIDTH_C'(cfg.tap_mask_b), WIDTH_C'(TOP_B)));
	assign step_c = galois(sr_c_q, cfg.tap_mask_c, TOP_C);

	// Clock bits; positions past the register read as zero
	assign ext_a = {{(32-WIDTH_A){1'b0}}, sr_a_q};
	assign ext_b = {{(32-WIDTH_B){1'b0}}, sr_b_q};
	assign ext_c = {{(32-WIDTH_C){1'b0}}, sr_c_q};
	assign ca  = ext_a[cfg.clock_pos_a];
	assign cb  = ext_b[cfg.clock_pos_b];
	assign cc  = ext_c[cfg.clock_pos_c];
	assign maj = (ca & cb) | (ca & cc) | (cb & cc);
	assign mv_a = (ca == maj);
	assign mv_b = (cb == maj);
	assign mv_c = (cc == maj);

	// Majority-step next values
	assign nxt_a = mv_a ? step_a : sr_a_q;
	assign nxt_b = mv_b ? step_b : sr_b_q;
	assign nxt_c = mv_c ? step_c : sr_c_q;

	// Keystream bit: feedback of moved registers for words, LSB parity for bytes
	always_comb begin
		if (cmd.word) begin
			ks_bit = (mv_a & sr_a_q[0]) ^ (mv_b & sr_b_q[0]) ^ (mv_c & sr_c_q[0]);
		end else begin
			ks_bit = nxt_a[0] ^ nxt_b[0] ^ nxt_c[0];
		end
	end

	// Shift registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_a_q <= '0;
			sr_b_q <= '0;
			sr_c_q <= '0;
		end else if (cmd.clear) begin
			sr_a_q <= '0;
			sr_b_q <= '0;
			sr_c_q <= '0;
		end else if (cmd.load_step) begin
			sr_a_q <= step_a ^ (inj_q[0] ? TOP_A : '0);
			sr_b_q <= step_b ^ (inj_q[0] ? TOP_B : '0);
			sr_c_q <= step_c ^ (inj_q[0] ? TOP_C : '0);
		end else if (cmd.mix_step || cmd.gen_step) begin
			sr_a_q <= nxt_a;
			sr_b_q <= nxt_b;
			sr_c_q <= nxt_c;
		end
	end

	// Request payload, injection shifter and keystream accumulator
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			inj_q  <= {in_data.frame_number, in_data.session_key};
			data_q <= in_data.data_in;
			ks_q   <= '0;
		end else begin
			if (cmd.load_step) begin
				inj_q <= inj_q >> 1;
			end
			if (cmd.gen_step) begin
				ks_q <= {ks_q[30:0], ks_bit};
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.keystream <= ks_q;
			if (cmd.word) begin
				res_q.data_out <= data_q ^ ks_q;
			end else begin
				res_q.data_out <= {24'b0, data_q[7:0] ^ ks_q[7:0]};
			end
		end
	end

	assign out_data = res_q;

endmodule

// ----- sv/mclk_ctrl.sv -----
// Controller state machine: sequences init, byte and word requests and
// owns the output valid flag. Depends on mclk_pkg.
`timescale 1ns / 1ps

module mclk_ctrl import mclk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             word_q, word_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State, counter and valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			word_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			word_q  <= word_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		word_d   = word_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.word = word_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_op)
						OP_INIT: begin
							cmd.clear = 1'b1;
							state_d   = ST_LOAD;
						end
						OP_BYTE: begin
							word_d  = 1'b0;
							state_d = ST_GEN;
						end
						OP_WORD: begin
							word_d  = 1'b1;
							state_d = ST_GEN;
						end
						default: ; // unused code: dropped
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load_step = 1'b1;
				if (cnt_q == LOAD_LAST) begin
					cnt_d   = '0;
					state_d = ST_MIX;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MIX: begin
				cmd.mix_step = 1'b1;
				if (cnt_q == MIX_LAST) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_GEN: begin
				cmd.gen_step = 1'b1;
				if (cnt_q == (word_q ? WORD_LAST : BYTE_LAST)) begin
					state_d = ST_EMIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Counter stays within the phase length
	a_mix_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) |-> (cnt_q <= MIX_LAST))
		else $error("mix counter overrun");

	a_byte_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN && !word_q) |-> (cnt_q <= BYTE_LAST))
		else $error("byte counter overrun");

	// A result only appears from the emit state
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside emit");

	// A valid request that starts work blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_op == OP_INIT || in_op == OP_BYTE || in_op == OP_WORD))
		|=> !in_ready)
		else $error("request taken while busy");

endmodule
